FILE: rtl/core/psg_pkg.sv
// Shared types and constants for the programmable sound generator core.
// No dependencies; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package psg_pkg;

    localparam int NUM_TONES = 3;
    localparam int NUM_CHANS = 4;
    localparam int PERIOD_W  = 10;
    localparam int ATT_W     = 4;
    localparam int BASE_W    = 10;
    localparam int SAMPLE_W  = 16;
    localparam int AMP_W     = ATT_W + BASE_W;
    localparam int SUM_W     = AMP_W + 4;
    localparam int SHIFT_W   = 16;

    // Item command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Register number that selects the noise control register
    localparam logic [2:0] NOISE_REG = 3'd6;
    // Noise rate selection that follows tone channel 2
    localparam logic [1:0] NOISE_RATE_TONE2 = 2'd3;

    localparam logic [ATT_W-1:0]    ATT_SILENT   = 4'hf;
    localparam logic [PERIOD_W-1:0] NOISE_RATE_0 = 10'h010;
    localparam logic [SHIFT_W-1:0]  NOISE_SEED   = 16'h0001;
    localparam logic [NUM_CHANS-1:0] PHASE_RESET = 4'b0101;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 18'sd32767;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -18'sd32768;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef logic [NUM_TONES-1:0][PERIOD_W-1:0] t_periods;
    typedef logic [NUM_CHANS-1:0][ATT_W-1:0]    t_attens;

    // Programmed register file contents as seen by the oscillators and mixer
    typedef struct packed {
        t_periods    tone_period;
        t_attens     atten;
        logic [2:0]  noise_ctl;
    } t_reg_state;

endpackage

`default_nettype wire

FILE: rtl/core/psg_tone_noise_generator_core.sv
// Four-channel tone and noise sound generator core: input and output channels
// with valid/stall, a step gain write port. Uses psg_pkg, psg_regfile, psg_osc, psg_mix.
//
// Input items carry i_cmd and i_data_byte. A write item (i_cmd = 0) stores one
// register byte and gives no result. A tick item (i_cmd = 1) steps the three
// tone dividers, the noise divider and the noise shift register, and gives one
// signed sample on o_sample. An item is taken when i_valid is high and o_stall
// is low; a sample is taken when o_valid is high and i_stall is low.
// One item is accepted per cycle while o_stall is low. The register file, dividers
// and operand register update at the accepting edge; the tick's sample then runs
// through the multiply, sum and saturate stage into the output register behind o_valid.
// When the receiver stalls, the finished sample holds in the output register
// and one more tick waits in the operand register; only then does o_stall rise.
// The step gain port is always ready and is written at i_cfg_valid; the user must
// see that it is changed only while no sample is in flight; the core does not
// enforce this. Synchronous reset restores all registers to silence, step gain
// 100, and empties the pipeline.
`default_nettype none

module psg_tone_noise_generator_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic                               i_cmd,
    input  wire logic [7:0]                         i_data_byte,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [psg_pkg::SAMPLE_W-1:0]     o_sample,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [psg_pkg::BASE_W-1:0]         i_cfg_data
);

    logic [psg_pkg::BASE_W-1:0]        r_step_gain;
    logic                              accept;
    logic                              wr;
    logic                              tick;
    logic                              noise_wr;
    logic                              block;
    psg_pkg::t_reg_state               regs;
    logic [psg_pkg::NUM_TONES-1:0]     tone_phase;
    logic                              noise_bit;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = block;
    assign accept      = i_valid && !block;
    assign wr          = accept && (i_cmd == psg_pkg::CMD_WRITE);
    assign tick        = accept && (i_cmd == psg_pkg::CMD_TICK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_gain <= 10'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_step_gain <= i_cfg_data;
        end
    end

    psg_regfile u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_byte     (i_data_byte),
        .o_regs     (regs),
        .o_noise_wr (noise_wr)
    );

    psg_osc u_osc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick),
        .i_reseed     (noise_wr),
        .i_regs       (regs),
        .o_tone_phase (tone_phase),
        .o_noise_bit  (noise_bit)
    );

    psg_mix u_mix (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (tick),
        .i_tone_phase  (tone_phase),
        .i_noise_bit   (noise_bit),
        .i_atten       (regs.atten),
        .i_step_gain   (r_step_gain),
        .i_stall       (i_stall),
        .o_block       (block),
        .o_valid       (o_valid),
        .o_sample      (o_sample)
    );

endmodule

`default_nettype wire

FILE: rtl/core/psg_regs.sv
// Register file of the sound generator: latched register number, tone periods,
// attenuations and noise control, written one byte at a time. Uses psg_pkg.
`default_nettype none

module psg_regfile (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire logic [7:0]        i_byte,
    output psg_pkg::t_reg_state    o_regs,
    output logic                   o_noise_wr
);

    logic [2:0]           r_latched, n_latched;
    psg_pkg::t_periods    r_period, n_period;
    psg_pkg::t_attens     r_atten, n_atten;
    logic [2:0]           r_noise_ctl, n_noise_ctl;
    logic [2:0]           sel;

    always_comb begin
        n_latched   = r_latched;
        n_period    = r_period;
        n_atten     = r_atten;
        n_noise_ctl = r_noise_ctl;
        o_noise_wr  = 1'b0;
        // A latch byte selects the target register for itself and later data bytes.
        sel = i_byte[7] ? i_byte[6:4] : r_latched;
        if (i_wr) begin
            if (i_byte[7]) begin
                n_latched = i_byte[6:4];
            end
            priority if (sel[0]) begin
                n_atten[sel[2:1]] = i_byte[3:0];
            end else if (sel == psg_pkg::NOISE_REG) begin
                n_noise_ctl = i_byte[2:0];
                o_noise_wr  = 1'b1;
            end else if (i_byte[7]) begin
                n_period[sel[2:1]][3:0] = i_byte[3:0];
            end else begin
                n_period[sel[2:1]][psg_pkg::PERIOD_W-1:4] = i_byte[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched   <= '0;
            r_period    <= '0;
            r_atten     <= {psg_pkg::NUM_CHANS{psg_pkg::ATT_SILENT}};
            r_noise_ctl <= '0;
        end else begin
            r_latched   <= n_latched;
            r_period    <= n_period;
            r_atten     <= n_atten;
            r_noise_ctl <= n_noise_ctl;
        end
    end

    assign o_regs.tone_period = r_period;
    assign o_regs.atten       = r_atten;
    assign o_regs.noise_ctl   = r_noise_ctl;

endmodule

`default_nettype wire

FILE: rtl/core/psg_osc.sv
// Tone dividers, noise divider and noise shift register of the sound generator.
// Steps once per tick item; uses psg_pkg for widths and the register struct.
`default_nettype none

module psg_osc (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_tick,
    input  wire logic                            i_reseed,
    input  wire psg_pkg::t_reg_state             i_regs,
    output logic [psg_pkg::NUM_TONES-1:0]        o_tone_phase,
    output logic                                 o_noise_bit
);

    logic [psg_pkg::NUM_CHANS-1:0][psg_pkg::PERIOD_W-1:0] r_count, n_count;
    logic [psg_pkg::NUM_CHANS-1:0]                        r_phase, n_phase;
    logic [psg_pkg::SHIFT_W-1:0]                          r_shift, n_shift;
    logic                                                 r_noise_bit, n_noise_bit;
    logic [psg_pkg::NUM_CHANS-1:0][psg_pkg::PERIOD_W-1:0] dec;
    logic                                                 fb;

    always_comb begin
        n_count     = r_count;
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_noise_bit = r_noise_bit;
        fb          = 1'b0;
        for (int i = 0; i < psg_pkg::NUM_CHANS; i++) begin
            dec[i] = (r_count[i] != '0) ? r_count[i] - 1'b1 : '0;
            n_count[i] = dec[i];
        end
        for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
            if (dec[i] == '0) begin
                n_count[i] = i_regs.tone_period[i];
                n_phase[i] = ~r_phase[i];
            end
            // A channel with a zero period holds its output high.
            if (i_regs.tone_period[i] == '0) begin
                n_phase[i] = 1'b1;
            end
        end
        if (dec[psg_pkg::NUM_TONES] == '0) begin
            if (i_regs.noise_ctl[1:0] == psg_pkg::NOISE_RATE_TONE2) begin
                n_count[psg_pkg::NUM_TONES] = i_regs.tone_period[psg_pkg::NUM_TONES-1];
            end else begin
                n_count[psg_pkg::NUM_TONES] = psg_pkg::NOISE_RATE_0 << i_regs.noise_ctl[1:0];
            end
            n_phase[psg_pkg::NUM_TONES] = ~r_phase[psg_pkg::NUM_TONES];
            // The shift register only advances on the rising edge of the noise phase.
            if (!r_phase[psg_pkg::NUM_TONES]) begin
                n_noise_bit = r_shift[0];
                fb = r_shift[0] ^ (i_regs.noise_ctl[2] & r_shift[3]);
                n_shift = {fb, r_shift[psg_pkg::SHIFT_W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_phase     <= psg_pkg::PHASE_RESET;
            r_shift     <= '0;
            r_noise_bit <= 1'b0;
        end else if (i_tick) begin
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_noise_bit <= n_noise_bit;
        end else if (i_reseed) begin
            r_shift <= psg_pkg::NOISE_SEED;
        end
    end

    // The mixer samples the state as it stands after this tick.
    assign o_tone_phase = n_phase[psg_pkg::NUM_TONES-1:0];
    assign o_noise_bit  = n_noise_bit;

endmodule

`default_nettype wire

FILE: rtl/core/psg_mix.sv
// Two-stage mixer of the sound generator: an operand register, then the
// volume-weighted sum with saturation into the output register. Uses psg_pkg.
`default_nettype none

module psg_mix (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_load,
    input  wire logic [psg_pkg::NUM_TONES-1:0]        i_tone_phase,
    input  wire logic                                 i_noise_bit,
    input  wire psg_pkg::t_attens                     i_atten,
    input  wire logic [psg_pkg::BASE_W-1:0]           i_step_gain,
    input  wire logic                                 i_stall,
    output logic                                      o_block,
    output logic                                      o_valid,
    output logic signed [psg_pkg::SAMPLE_W-1:0]       o_sample
);

    logic                                   r_s1_vld;
    logic [psg_pkg::NUM_TONES-1:0]          r_s1_phase;
    logic                                   r_s1_noise;
    psg_pkg::t_attens                       r_s1_atten;
    logic                                   r_out_vld;
    logic signed [psg_pkg::SAMPLE_W-1:0]    r_sample, n_sample;
    logic                                   adv;
    logic [psg_pkg::AMP_W-1:0]              amp [psg_pkg::NUM_CHANS];
    logic signed [psg_pkg::SUM_W-1:0]       term [psg_pkg::NUM_CHANS];
    logic signed [psg_pkg::SUM_W-1:0]       sum;

    assign adv     = !r_out_vld || !i_stall;
    assign o_block = r_s1_vld && !adv;

    always_comb begin
        for (int i = 0; i < psg_pkg::NUM_CHANS; i++) begin
            amp[i] = (psg_pkg::ATT_SILENT - r_s1_atten[i]) * i_step_gain;
            term[i] = $signed({{(psg_pkg::SUM_W - psg_pkg::AMP_W){1'b0}}, amp[i]});
        end
        for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
            if (!r_s1_phase[i]) begin
                term[i] = -term[i];
            end
        end
        if (!r_s1_noise) begin
            term[psg_pkg::NUM_TONES] = '0;
        end
        sum = term[0] + term[1] + term[2] + term[3];
        priority if (sum > psg_pkg::SUM_MAX) begin
            n_sample = psg_pkg::SAMPLE_MAX;
        end else if (sum < psg_pkg::SUM_MIN) begin
            n_sample = psg_pkg::SAMPLE_MIN;
        end else begin
            n_sample = sum[psg_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_load || (r_s1_vld && !adv);
            if (adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s1_phase <= i_tone_phase;
            r_s1_noise <= i_noise_bit;
            r_s1_atten <= i_atten;
        end
        if (adv) begin
            r_sample <= n_sample;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_sample = r_sample;

endmodule

`default_nettype wire

FILE: rtl/core/psg_checker.sv
// Port-level checker for the sound generator core, attached by bind.
// Depends on psg_pkg and on the top level's ports only.
`default_nettype none

module psg_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic                               o_stall,
    input  wire logic                               i_cmd,
    input  wire logic                               o_valid,
    input  wire logic                               i_stall,
    input  wire logic [psg_pkg::SAMPLE_W-1:0]       o_sample
);

    // Input is held back only while a finished sample is itself held back.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked output");

    // Every accepted tick is checked for a sample on the output once it has passed the operand and output registers.
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_cmd == psg_pkg::CMD_TICK) |=> ##1 o_valid)
        else $error("tick item gave no sample");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sample)))
        else $error("stalled sample changed or vanished");

endmodule

bind psg_tone_noise_generator_core psg_checker u_psg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .i_cmd    (i_cmd),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_sample (o_sample)
);

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for psg_tone_noise_generator_core: an in-bench model of the
// tone dividers, noise shift register and mixer predicts every sample of a tick item.
// Depends on psg_pkg and the core RTL only; stimulus is directed first, then random.

class tone_noise_scoreboard;
    logic [psg_pkg::BASE_W-1:0]   step_gain;
    logic [2:0]                   latched_reg;
    logic [psg_pkg::PERIOD_W-1:0] tone_period [psg_pkg::NUM_TONES];
    logic [psg_pkg::ATT_W-1:0]    atten [psg_pkg::NUM_CHANS];
    logic [2:0]                   noise_ctl;
    logic [psg_pkg::SHIFT_W-1:0]  noise_lfsr;
    logic [psg_pkg::PERIOD_W-1:0] divider [psg_pkg::NUM_CHANS];
    logic                         phase [psg_pkg::NUM_CHANS];
    logic                         noise_out;
    logic signed [psg_pkg::SAMPLE_W-1:0] expected_samples [$];
    int                           errors;

    function new();
        step_gain   = 10'd100;
        latched_reg = 3'd0;
        noise_ctl   = 3'd0;
        noise_lfsr  = '0;
        noise_out   = 1'b0;
        errors      = 0;
        for (int i = 0; i < psg_pkg::NUM_CHANS; i++) begin
            atten[i]   = psg_pkg::ATT_SILENT;
            divider[i] = '0;
            phase[i]   = psg_pkg::PHASE_RESET[i];
            if (i < psg_pkg::NUM_TONES) tone_period[i] = '0;
        end
    endfunction

    function int pending();
        return expected_samples.size();
    endfunction

    // Applies one accepted input item; a tick queues the sample it must produce.
    function void note_item(logic cmd, logic [7:0] data);
        logic [3:0] nib;
        logic [1:0] chan;
        logic [1:0] rate;
        logic       fb;
        int         amp;
        int         sum;
        nib = data[3:0];
        if (cmd == psg_pkg::CMD_WRITE) begin
            if (data[7]) latched_reg = data[6:4];
            chan = latched_reg[2:1];
            if (latched_reg[0]) begin
                atten[chan] = nib;
            end else if (latched_reg == psg_pkg::NOISE_REG) begin
                noise_ctl  = nib[2:0];
                noise_lfsr = psg_pkg::NOISE_SEED;
            end else if (data[7]) begin
                tone_period[chan][3:0] = nib;
            end else begin
                tone_period[chan][9:4] = data[5:0];
            end
            return;
        end
        for (int i = 0; i < psg_pkg::NUM_CHANS; i++)
            if (divider[i] != 0) divider[i] = divider[i] - 1'b1;
        for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
            if (divider[i] == 0) begin
                divider[i] = tone_period[i];
                phase[i]   = ~phase[i];
            end
            if (tone_period[i] == 0) phase[i] = 1'b1;
        end
        if (divider[3] == 0) begin
            rate = noise_ctl[1:0];
            divider[3] = (rate == psg_pkg::NOISE_RATE_TONE2) ? tone_period[2]
                                                             : (psg_pkg::NOISE_RATE_0 << rate);
            phase[3] = ~phase[3];
            // The shift register only advances on the rising half of the noise divider.
            if (phase[3]) begin
                fb        = noise_lfsr[0];
                noise_out = fb;
                if (noise_ctl[2]) fb = fb ^ noise_lfsr[3];
                noise_lfsr = {fb, noise_lfsr[15:1]};
            end
        end
        sum = 0;
        for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
            amp = (int'(psg_pkg::ATT_SILENT) - int'(atten[i])) * int'(step_gain);
            sum += phase[i] ? amp : -amp;
        end
        if (noise_out)
            sum += (int'(psg_pkg::ATT_SILENT) - int'(atten[3])) * int'(step_gain);
        if (sum > int'(psg_pkg::SAMPLE_MAX)) sum = int'(psg_pkg::SAMPLE_MAX);
        if (sum < int'(psg_pkg::SAMPLE_MIN)) sum = int'(psg_pkg::SAMPLE_MIN);
        expected_samples.push_back(sum[15:0]);
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH: %s", msg);
    endtask

    task check_sample(logic signed [psg_pkg::SAMPLE_W-1:0] got);
        logic signed [psg_pkg::SAMPLE_W-1:0] want;
        if (expected_samples.size() == 0) begin
            report($sformatf("sample %0d arrived with no tick pending", got));
        end else begin
            want = expected_samples.pop_front();
            if (got !== want)
                report($sformatf("sample got %0d, expected %0d", got, want));
        end
    endtask
endclass

module testbench;
    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic                                i_cmd;
    logic [7:0]                          i_data_byte;
    logic                                o_valid;
    logic                                i_stall;
    logic signed [psg_pkg::SAMPLE_W-1:0] o_sample;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [psg_pkg::BASE_W-1:0]          i_cfg_data;

    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_request;

    tone_noise_scoreboard sb = new();

    psg_tone_noise_generator_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sample    (o_sample),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8 * 300000);
        $display("psg_tone_noise_generator_core verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_item(i_cmd, i_data_byte);
            if (o_valid && !i_stall) sb.check_sample(o_sample);
        end
    end

    // Sample receiver: short random stalls, plus one long hold-off on request.
    initial begin
        int burst;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall = 1'b1;
                repeat (150) @(negedge i_clk);
                i_stall = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 8);
                i_stall = 1'b1;
                repeat (burst) @(negedge i_clk);
                i_stall = 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic cmd, input logic [7:0] data);
        int gap;
        if (tx_idle_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 8);
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_cmd       = cmd;
        i_data_byte = data;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_byte(input logic [7:0] data);
        send_item(psg_pkg::CMD_WRITE, data);
    endtask

    task automatic tick(input int count);
        repeat (count) send_item(psg_pkg::CMD_TICK, 8'h00);
    endtask

    task automatic drain_pipeline();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        // A trailing write item leaves nothing to wait on, so allow for its latency.
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_step_gain(input logic [psg_pkg::BASE_W-1:0] value);
        drain_pipeline();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.step_gain = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                tick(1);
            else if (pick < 75)
                write_byte({1'b1, 3'($urandom), 4'($urandom)});
            else if (pick < 90)
                // Mostly small high period bits so the tones toggle often.
                write_byte({1'b0, 1'($urandom), 6'($urandom_range(0, 3))});
            else
                write_byte(8'($urandom));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cmd        = psg_pkg::CMD_WRITE;
        i_data_byte  = 8'h00;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_request = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n    = 1'b1;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // Silent reset state, then a loud tone 0 with a zero period held at plus.
        tick(1);
        write_byte(8'h90);
        tick(1);
        // High period bits 7..6 of a data byte are dropped.
        write_byte(8'h81);
        write_byte(8'h7f);
        tick(1);
        write_byte(8'h8f);
        write_byte(8'h00);
        write_byte(8'h82);
        tick(1);
        write_byte(8'hb0);
        write_byte(8'ha1);
        write_byte(8'hd0);
        write_byte(8'hc3);
        // Loud noise before any noise write: the shift register is still all zero.
        write_byte(8'hf0);
        tick(2);
        write_byte(8'he4);
        tick(2);
        write_byte(8'he7);
        write_byte(8'h03);
        tick(3);

        // Full scale volume drives the mix into both saturation limits.
        set_step_gain(10'd1023);
        tick(8);

        set_step_gain(10'd0);
        run_random(100);

        set_step_gain(10'd546);
        hold_request = 1'b1;
        run_random(200);

        set_step_gain(10'($urandom_range(2, 1023)));
        run_random(250);

        set_step_gain(10'd1);
        run_random(100);

        set_step_gain(10'($urandom_range(2, 1023)));
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(370);

        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("psg_tone_noise_generator_core verification clean");
        else
            $display("psg_tone_noise_generator_core verification failed");
        $finish;
    end
endmodule
